// ----- design/rad_pkg.sv -----
// Shared types and constants for the resource allocator with deadlock detection.
// Holds the request and result payload structs, the function, result and state codes.
// No dependencies.
`timescale 1ns / 1ps

package rad_pkg;

    localparam logic [7:0] IPC_RESET = 8'd10;

    typedef enum logic [2:0] {
        FN_REQUEST  = 3'd0,
        FN_RELEASE  = 3'd1,
        FN_TERMINATE = 3'd2,
        FN_DETECT   = 3'd3,
        FN_ADMIT    = 3'd4,
        FN_DISPATCH = 3'd5,
        FN_INIT     = 3'd6
    } func_t;

    typedef enum logic [2:0] {
        KD_GRANT   = 3'd0,
        KD_TURN    = 3'd1,
        KD_BLOCKED = 3'd2,
        KD_KILL    = 3'd3,
        KD_CLEAR   = 3'd4,
        KD_ACK     = 3'd5,
        KD_REJECT  = 3'd6
    } kind_t;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] slot;
        logic [2:0] resource;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] target_slot;
        logic [2:0] resource_res;
        logic       last;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_REQ_GRANT,
        ST_REQ_BLOCK,
        ST_REL_CHK,
        ST_REL_TURN,
        ST_TERM_ACK,
        ST_DET_INIT,
        ST_DF_SCAN,
        ST_DF_RD,
        ST_DF_ACC,
        ST_DF_NEXT,
        ST_DF_PICK,
        ST_DET_KILL,
        ST_DET_END,
        ST_DET_CLEAR,
        ST_AD_SCAN,
        ST_DS_SCAN,
        ST_INIT,
        ST_REJECT,
        ST_FA_START,
        ST_RM_RD,
        ST_RM_WR,
        ST_RM_DONE,
        ST_FA_RD,
        ST_FA_CHK,
        ST_FA_NEXT,
        ST_GW_TEST,
        ST_GW_RD,
        ST_GW_HOLD
    } state_t;

    // Add two unit counts, clamping at the 8-bit ceiling
    function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

endpackage

// ----- design/resource_allocator_deadlock_detect.sv -----
// Top level of the resource allocator: sequencer, state tables and the two RAMs.
// Depends on rad_pkg, rad_ram and rad_outreg.
`timescale 1ns / 1ps

// Resource allocator with multi-instance deadlock detection. One request is
// taken at a time; cmd_stall stays high until the sequencer has issued every
// result of that request into the output register, which the consumer drains
// through res_valid/res_stall. Terminate and detect walk the slot and class
// tables through the held-count memory, which has one read and one write
// port: freeing a slot drops it from its wait queue if it is blocked, then
// returns its units class by class and grants waiters of each class; each
// detection round rescans the slots while a pass finds one able to finish,
// adding back its holdings, then picks the lowest unfinished slot as victim,
// and the round is repeated once for every victim. Output stalls can hold
// any of these steps.

module resource_allocator_deadlock_detect
    import rad_pkg::*;
#(
    parameter int SLOTS   = 16,
    parameter int CLASSES = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  cmd_t       cmd,
    output logic       res_valid,
    input  logic       res_stall,
    output res_t       res,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);

    localparam int SW   = $clog2(SLOTS);
    localparam int CW   = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam int AW   = SW + CW;
    localparam int DEPTH = (1 << SW) * (1 << CW);

    // Control and table registers
    state_t state_reg, state_next;
    state_t fa_ret_reg, fa_ret_next;
    state_t gw_ret_reg, gw_ret_next;
    logic   gw_one_reg, gw_one_next;
    cmd_t   cmd_reg, cmd_next;
    logic [SW-1:0]   sl_reg, sl_next;
    logic [SW-1:0]   idx_reg, idx_next;
    logic [SW-1:0]   w_reg, w_next;
    logic [CW-1:0]   cls_reg, cls_next;
    logic [CNTW-1:0] k_reg, k_next;
    logic [CNTW-1:0] n_reg, n_next;
    logic [7:0]      ipc_reg;
    logic [SW-1:0]   rr_reg, rr_next;
    logic [CLASSES-1:0][7:0]      free_reg, free_next;
    logic [CLASSES-1:0][7:0]      work_reg, work_next;
    logic [CLASSES-1:0][SW-1:0]   head_reg, head_next;
    logic [CLASSES-1:0][SW-1:0]   tail_reg, tail_next;
    logic [CLASSES-1:0][CNTW-1:0] qcnt_reg, qcnt_next;
    logic [SLOTS-1:0]  occ_reg, occ_next;
    logic [SLOTS-1:0]  blk_reg, blk_next;
    logic [SLOTS-1:0]  done_reg, done_next;
    logic              prog_reg, prog_next;
    logic [SLOTS-1:0][CLASSES-1:0] pend_reg, pend_next;
    logic [SLOTS-1:0][CLASSES-1:0] hvld_reg, hvld_next;
    logic              hrv_reg;

    // Memory ports
    logic [SW-1:0] h_ra_slot;
    logic          h_we;
    logic [SW-1:0] h_wa_slot;
    logic [7:0]    h_wd;
    logic [7:0]    h_rd;
    logic [7:0]    held_q;
    logic [SW-1:0] q_ra_pos;
    logic          q_we;
    logic [SW-1:0] q_wa_pos;
    logic [SW-1:0] q_wd;
    logic [SW-1:0] q_rd;

    // Result issue
    logic emit;
    res_t emit_data;
    logic emit_ok;

    // Table probes
    logic [SW-1:0]      probe;
    logic [CLASSES-1:0] pend_row;
    logic               occ_bit;
    logic               blk_bit;
    logic               fin_ok;
    logic [CW-1:0]      rm_cls;
    logic               s_ok;
    logic               r_ok;

    function automatic logic [SW-1:0] pos_add(input logic [SW-1:0] a,
                                              input logic [CNTW-1:0] b);
        logic [SW+1:0] sum;
        sum = (SW+2)'(a) + (SW+2)'(b);
        if (sum >= (SW+2)'(SLOTS))
        begin
            sum = sum - (SW+2)'(SLOTS);
        end
        return sum[SW-1:0];
    endfunction

    function automatic res_t mk_res(input logic [2:0] kind, input logic [SW-1:0] s,
                                    input logic [CW-1:0] c, input logic last);
        res_t r;
        r.kind         = kind;
        r.target_slot  = 4'(s);
        r.resource_res = 3'(c);
        r.last         = last;
        return r;
    endfunction

    assign cmd_stall = (state_reg != ST_IDLE);
    assign held_q    = hrv_reg ? h_rd : 8'd0;
    assign s_ok      = (32'(cmd_reg.slot) < SLOTS);
    assign r_ok      = (32'(cmd_reg.resource) < CLASSES);

    // Pick the slot that the current state inspects
    always_comb
    begin
        unique case (state_reg)
            ST_DF_SCAN, ST_DF_RD, ST_DF_ACC, ST_DF_NEXT, ST_DF_PICK,
            ST_AD_SCAN, ST_DS_SCAN: probe = idx_reg;
            default:                probe = sl_reg;
        endcase
    end

    assign pend_row = pend_reg[probe];
    assign occ_bit  = occ_reg[probe];
    assign blk_bit  = blk_reg[probe];

    // Check whether the probed slot can finish with the current work vector
    always_comb
    begin
        fin_ok = 1'b1;
        rm_cls = '0;
        for (int c = 0; c < CLASSES; c++)
        begin
            if (pend_row[c] && (work_reg[c] == 8'd0))
            begin
                fin_ok = 1'b0;
            end
            if (pend_row[c])
            begin
                rm_cls = CW'(c);
            end
        end
    end

    // Held-count read address follows the state
    always_comb
    begin
        unique case (state_reg)
            ST_GW_RD:          h_ra_slot = q_rd;
            ST_GW_HOLD:        h_ra_slot = w_reg;
            ST_DF_RD, ST_DF_ACC: h_ra_slot = idx_reg;
            default:           h_ra_slot = sl_reg;
        endcase
    end

    // Wait-queue read address
    always_comb
    begin
        if (state_reg == ST_RM_RD)
        begin
            q_ra_pos = pos_add(head_reg[cls_reg], k_reg);
        end
        else
        begin
            q_ra_pos = head_reg[cls_reg];
        end
    end

    // Sequencer: next state, table updates, memory writes and result issue
    always_comb
    begin
        state_next  = state_reg;
        fa_ret_next = fa_ret_reg;
        gw_ret_next = gw_ret_reg;
        gw_one_next = gw_one_reg;
        cmd_next    = cmd_reg;
        sl_next     = sl_reg;
        idx_next    = idx_reg;
        w_next      = w_reg;
        cls_next    = cls_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        rr_next     = rr_reg;
        free_next   = free_reg;
        work_next   = work_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        qcnt_next   = qcnt_reg;
        occ_next    = occ_reg;
        blk_next    = blk_reg;
        done_next   = done_reg;
        prog_next   = prog_reg;
        pend_next   = pend_reg;
        hvld_next   = hvld_reg;
        h_we        = 1'b0;
        h_wa_slot   = sl_reg;
        h_wd        = 8'd0;
        q_we        = 1'b0;
        q_wa_pos    = tail_reg[cls_reg];
        q_wd        = sl_reg;
        emit        = 1'b0;
        emit_data   = mk_res(KD_REJECT, '0, '0, 1'b1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    sl_next    = SW'(cmd.slot);
                    cls_next   = CW'(cmd.resource);
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                unique case (cmd_reg.func)
                    FN_REQUEST:
                    begin
                        if (!s_ok || !r_ok || !occ_bit || blk_bit)
                        begin
                            state_next = ST_REJECT;
                        end
                        else if (free_reg[cls_reg] != 8'd0)
                        begin
                            state_next = ST_REQ_GRANT;
                        end
                        else
                        begin
                            state_next = ST_REQ_BLOCK;
                        end
                    end
                    FN_RELEASE:
                    begin
                        state_next = (s_ok && r_ok) ? ST_REL_CHK : ST_REJECT;
                    end
                    FN_TERMINATE:
                    begin
                        if (s_ok && occ_bit)
                        begin
                            fa_ret_next = ST_TERM_ACK;
                            state_next  = ST_FA_START;
                        end
                        else
                        begin
                            state_next = ST_REJECT;
                        end
                    end
                    FN_DETECT:
                    begin
                        state_next = ST_DET_INIT;
                    end
                    FN_ADMIT:
                    begin
                        idx_next   = '0;
                        state_next = ST_AD_SCAN;
                    end
                    FN_DISPATCH:
                    begin
                        idx_next   = rr_reg;
                        k_next     = '0;
                        state_next = ST_DS_SCAN;
                    end
                    FN_INIT:
                    begin
                        state_next = ST_INIT;
                    end
                    default:
                    begin
                        state_next = ST_REJECT;
                    end
                endcase
            end

            // Grant one unit to the requesting slot
            ST_REQ_GRANT:
            begin
                emit      = 1'b1;
                emit_data = mk_res(KD_GRANT, sl_reg, cls_reg, 1'b1);
                if (emit_ok)
                begin
                    free_next[cls_reg] = free_reg[cls_reg] - 8'd1;
                    h_we       = 1'b1;
                    h_wa_slot  = sl_reg;
                    h_wd       = held_q + 8'd1;
                    hvld_next[sl_reg][cls_reg] = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // Block the slot and append it to the class queue
            ST_REQ_BLOCK:
            begin
                emit      = 1'b1;
                emit_data = mk_res(KD_BLOCKED, sl_reg, cls_reg, 1'b1);
                if (emit_ok)
                begin
                    blk_next[sl_reg]          = 1'b1;
                    pend_next[sl_reg][cls_reg] = 1'b1;
                    if (32'(qcnt_reg[cls_reg]) < SLOTS)
                    begin
                        q_we     = 1'b1;
                        q_wa_pos = tail_reg[cls_reg];
                        q_wd     = sl_reg;
                        tail_next[cls_reg] = pos_add(tail_reg[cls_reg], CNTW'(1));
                        qcnt_next[cls_reg] = qcnt_reg[cls_reg] + CNTW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            // Return one unit, then wake at most one waiter
            ST_REL_CHK:
            begin
                if (held_q == 8'd0)
                begin
                    state_next = ST_REJECT;
                end
                else
                begin
                    h_we      = 1'b1;
                    h_wa_slot = sl_reg;
                    h_wd      = held_q - 8'd1;
                    hvld_next[sl_reg][cls_reg] = 1'b1;
                    if (free_reg[cls_reg] != 8'hFF)
                    begin
                        free_next[cls_reg] = free_reg[cls_reg] + 8'd1;
                    end
                    gw_one_next = 1'b1;
                    gw_ret_next = ST_REL_TURN;
                    state_next  = ST_GW_TEST;
                end
            end

            ST_REL_TURN:
            begin
                emit      = 1'b1;
                emit_data = mk_res(KD_TURN, sl_reg, '0, 1'b1);
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_TERM_ACK:
            begin
                emit      = 1'b1;
                emit_data = mk_res(KD_ACK, sl_reg, '0, 1'b1);
                if (emit_ok)
                begin
                    occ_next[sl_reg] = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            // Load the work vector and the finished set for one detection round
            ST_DET_INIT:
            begin
                work_next  = free_reg;
                done_next  = ~occ_reg;
                prog_next  = 1'b0;
                idx_next   = '0;
                state_next = ST_DF_SCAN;
            end

            ST_DF_SCAN:
            begin
                if (!done_reg[idx_reg] && fin_ok)
                begin
                    done_next[idx_reg] = 1'b1;
                    prog_next  = 1'b1;
                    cls_next   = '0;
                    state_next = ST_DF_RD;
                end
                else
                begin
                    state_next = ST_DF_NEXT;
                end
            end

            ST_DF_RD:
            begin
                state_next = ST_DF_ACC;
            end

            // Add the finishing slot's holdings back into the work vector
            ST_DF_ACC:
            begin
                work_next[cls_reg] = sat_add8(work_reg[cls_reg], held_q);
                if (cls_reg == CW'(CLASSES - 1))
                begin
                    state_next = ST_DF_NEXT;
                end
                else
                begin
                    cls_next   = cls_reg + CW'(1);
                    state_next = ST_DF_RD;
                end
            end

            // Advance the scan; rescan while a pass made progress
            ST_DF_NEXT:
            begin
                if (idx_reg == SW'(SLOTS - 1))
                begin
                    idx_next = '0;
                    if (prog_reg)
                    begin
                        prog_next  = 1'b0;
                        state_next = ST_DF_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DF_PICK;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + SW'(1);
                    state_next = ST_DF_SCAN;
                end
            end

            // Find the lowest slot left unfinished
            ST_DF_PICK:
            begin
                if (!done_reg[idx_reg])
                begin
                    sl_next    = idx_reg;
                    state_next = ST_DET_KILL;
                end
                else if (idx_reg == SW'(SLOTS - 1))
                begin
                    state_next = ST_DET_CLEAR;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end

            ST_DET_KILL:
            begin
                emit      = 1'b1;
                emit_data = mk_res(KD_KILL, sl_reg, '0, 1'b0);
                if (emit_ok)
                begin
                    fa_ret_next = ST_DET_END;
                    state_next  = ST_FA_START;
                end
            end

            ST_DET_END:
            begin
                occ_next[sl_reg] = 1'b0;
                state_next       = ST_DET_INIT;
            end

            ST_DET_CLEAR:
            begin
                emit      = 1'b1;
                emit_data = mk_res(KD_CLEAR, '0, '0, 1'b1);
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end

            // Take the lowest free slot
            ST_AD_SCAN:
            begin
                if (!occ_bit)
                begin
                    emit      = 1'b1;
                    emit_data = mk_res(KD_ACK, idx_reg, '0, 1'b1);
                    if (emit_ok)
                    begin
                        occ_next[idx_reg]  = 1'b1;
                        blk_next[idx_reg]  = 1'b0;
                        hvld_next[idx_reg] = '0;
                        pend_next[idx_reg] = '0;
                        state_next         = ST_IDLE;
                    end
                end
                else if (idx_reg == SW'(SLOTS - 1))
                begin
                    state_next = ST_REJECT;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end

            // Round-robin search for a ready slot
            ST_DS_SCAN:
            begin
                if (occ_bit && !blk_bit)
                begin
                    emit      = 1'b1;
                    emit_data = mk_res(KD_TURN, idx_reg, '0, 1'b1);
                    if (emit_ok)
                    begin
                        rr_next    = pos_add(idx_reg, CNTW'(1));
                        state_next = ST_IDLE;
                    end
                end
                else if (k_reg == CNTW'(SLOTS - 1))
                begin
                    state_next = ST_REJECT;
                end
                else
                begin
                    idx_next = pos_add(idx_reg, CNTW'(1));
                    k_next   = k_reg + CNTW'(1);
                end
            end

            ST_INIT:
            begin
                emit      = 1'b1;
                emit_data = mk_res(KD_ACK, '0, '0, 1'b1);
                if (emit_ok)
                begin
                    hvld_next = '0;
                    pend_next = '0;
                    occ_next  = '0;
                    blk_next  = '0;
                    head_next = '0;
                    tail_next = '0;
                    qcnt_next = '0;
                    rr_next   = '0;
                    for (int c = 0; c < CLASSES; c++)
                    begin
                        free_next[c] = ipc_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_REJECT:
            begin
                emit      = 1'b1;
                emit_data = mk_res(KD_REJECT, '0, '0, 1'b1);
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end

            // Free a slot: drop it from its wait queue first
            ST_FA_START:
            begin
                if (blk_bit)
                begin
                    cls_next   = rm_cls;
                    k_next     = '0;
                    n_next     = '0;
                    state_next = ST_RM_RD;
                end
                else
                begin
                    state_next = ST_RM_DONE;
                end
            end

            ST_RM_RD:
            begin
                if (k_reg < qcnt_reg[cls_reg])
                begin
                    state_next = ST_RM_WR;
                end
                else
                begin
                    qcnt_next[cls_reg] = n_reg;
                    tail_next[cls_reg] = pos_add(head_reg[cls_reg], n_reg);
                    state_next         = ST_RM_DONE;
                end
            end

            // Compact the queue in place, skipping the dying slot
            ST_RM_WR:
            begin
                if (q_rd != sl_reg)
                begin
                    q_we     = 1'b1;
                    q_wa_pos = pos_add(head_reg[cls_reg], n_reg);
                    q_wd     = q_rd;
                    n_next   = n_reg + CNTW'(1);
                end
                k_next     = k_reg + CNTW'(1);
                state_next = ST_RM_RD;
            end

            ST_RM_DONE:
            begin
                blk_next[sl_reg]  = 1'b0;
                pend_next[sl_reg] = '0;
                cls_next          = '0;
                state_next        = ST_FA_RD;
            end

            ST_FA_RD:
            begin
                state_next = ST_FA_CHK;
            end

            // Return the slot's units of this class and wake waiters
            ST_FA_CHK:
            begin
                if (held_q != 8'd0)
                begin
                    free_next[cls_reg] = sat_add8(free_reg[cls_reg], held_q);
                    h_we        = 1'b1;
                    h_wa_slot   = sl_reg;
                    h_wd        = 8'd0;
                    hvld_next[sl_reg][cls_reg] = 1'b1;
                    gw_one_next = 1'b0;
                    gw_ret_next = ST_FA_NEXT;
                    state_next  = ST_GW_TEST;
                end
                else
                begin
                    state_next = ST_FA_NEXT;
                end
            end

            ST_FA_NEXT:
            begin
                if (cls_reg == CW'(CLASSES - 1))
                begin
                    state_next = fa_ret_reg;
                end
                else
                begin
                    cls_next   = cls_reg + CW'(1);
                    state_next = ST_FA_RD;
                end
            end

            // Grant queued waiters while units are free
            ST_GW_TEST:
            begin
                if ((qcnt_reg[cls_reg] != '0) && (free_reg[cls_reg] != 8'd0))
                begin
                    state_next = ST_GW_RD;
                end
                else
                begin
                    state_next = gw_ret_reg;
                end
            end

            ST_GW_RD:
            begin
                w_next     = q_rd;
                state_next = ST_GW_HOLD;
            end

            ST_GW_HOLD:
            begin
                emit      = 1'b1;
                emit_data = mk_res(KD_GRANT, w_reg, cls_reg, 1'b0);
                if (emit_ok)
                begin
                    h_we      = 1'b1;
                    h_wa_slot = w_reg;
                    h_wd      = held_q + 8'd1;
                    hvld_next[w_reg][cls_reg] = 1'b1;
                    free_next[cls_reg] = free_reg[cls_reg] - 8'd1;
                    head_next[cls_reg] = pos_add(head_reg[cls_reg], CNTW'(1));
                    qcnt_next[cls_reg] = qcnt_reg[cls_reg] - CNTW'(1);
                    blk_next[w_reg]          = 1'b0;
                    pend_next[w_reg][cls_reg] = 1'b0;
                    state_next = gw_one_reg ? gw_ret_reg : ST_GW_TEST;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state; reset loads the default unit count per class
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fa_ret_reg <= ST_IDLE;
            gw_ret_reg <= ST_IDLE;
            gw_one_reg <= 1'b0;
            cmd_reg    <= '0;
            sl_reg     <= '0;
            idx_reg    <= '0;
            w_reg      <= '0;
            cls_reg    <= '0;
            k_reg      <= '0;
            n_reg      <= '0;
            rr_reg     <= '0;
            for (int c = 0; c < CLASSES; c++)
            begin
                free_reg[c] <= IPC_RESET;
            end
            work_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            qcnt_reg   <= '0;
            occ_reg    <= '0;
            blk_reg    <= '0;
            done_reg   <= '0;
            prog_reg   <= 1'b0;
            pend_reg   <= '0;
            hvld_reg   <= '0;
            hrv_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fa_ret_reg <= fa_ret_next;
            gw_ret_reg <= gw_ret_next;
            gw_one_reg <= gw_one_next;
            cmd_reg    <= cmd_next;
            sl_reg     <= sl_next;
            idx_reg    <= idx_next;
            w_reg      <= w_next;
            cls_reg    <= cls_next;
            k_reg      <= k_next;
            n_reg      <= n_next;
            rr_reg     <= rr_next;
            free_reg   <= free_next;
            work_reg   <= work_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            qcnt_reg   <= qcnt_next;
            occ_reg    <= occ_next;
            blk_reg    <= blk_next;
            done_reg   <= done_next;
            prog_reg   <= prog_next;
            pend_reg   <= pend_next;
            hvld_reg   <= hvld_next;
            hrv_reg    <= hvld_reg[h_ra_slot][cls_reg];
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipc_reg <= IPC_RESET;
        end
        else if (cfg_we)
        begin
            ipc_reg <= cfg_data;
        end
    end

    rad_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_held_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (AW'({h_wa_slot, cls_reg})),
        .wdata (h_wd),
        .raddr (AW'({h_ra_slot, cls_reg})),
        .rdata (h_rd)
    );

    rad_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (AW'({cls_reg, q_wa_pos})),
        .wdata (q_wd),
        .raddr (AW'({cls_reg, q_ra_pos})),
        .rdata (q_rd)
    );

    rad_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (emit_data),
        .ready     (emit_ok),
        .res_valid (res_valid),
        .res       (res),
        .res_stall (res_stall)
    );

endmodule

// ----- design/rad_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the held-count and wait-queue stores.
`timescale 1ns / 1ps

module rad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/rad_outreg.sv -----
// Result output register: holds one result until the consumer takes it.
// Depends on rad_pkg for the result struct.
`timescale 1ns / 1ps

module rad_outreg
    import rad_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic ready,
    output logic res_valid,
    output res_t res,
    input  logic res_stall
);

    logic valid_reg;
    logic valid_next;
    res_t data_reg;
    res_t data_next;

    // Take a new result when empty or when the held one leaves this cycle
    assign ready = !valid_reg || !res_stall;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ready)
        begin
            valid_next = push;
            if (push)
            begin
                data_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            data_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            data_reg  <= data_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = data_reg;

endmodule

// ----- dv/tb_resource_allocator_deadlock_detect.sv -----
// Testbench for resource_allocator_deadlock_detect: a directed table, then random phases.
// Every result is checked against a predictor of the allocator kept in this file.
// Depends on rad_pkg and the resource_allocator_deadlock_detect RTL.
`timescale 1ns / 1ps

module tb_resource_allocator_deadlock_detect;
    import rad_pkg::*;

    localparam int NSLOT = 16;
    localparam int NCLS = 8;
    localparam logic [2:0] FN_UNDEF = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_stall;
    cmd_t       cmd;
    logic       res_valid;
    logic       res_stall;
    res_t       res;
    logic       cfg_we;
    logic [7:0] cfg_data;

    resource_allocator_deadlock_detect dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // Allocator state as the predictor sees it
    logic [7:0] units_per_class;
    logic [7:0] free_units [NCLS];
    logic [7:0] held_units [NSLOT][NCLS];
    bit         waiting_on [NSLOT][NCLS];
    bit         slot_used [NSLOT];
    bit         slot_blocked [NSLOT];
    logic [3:0] waitq [NCLS][NSLOT];
    int         waitq_head [NCLS];
    int         waitq_tail [NCLS];
    int         waitq_cnt [NCLS];
    int         rr_next;

    res_t step_results[$];
    res_t pending_results[$];

    int  n_errors;
    int  n_requests;
    int  n_results;
    int  n_kills;
    int  n_blocks;
    bit  long_hold;

    typedef struct {
        bit         wr;
        logic [7:0] val;
        cmd_t       c;
        bit         chk;
        res_t       e;
    } row_t;

    row_t directed[$];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop on a hung run
    initial
    begin
        #500_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void emit(kind_t k, int t, int r);
        res_t x;
        x.kind = k;
        x.target_slot = t[3:0];
        x.resource_res = r[2:0];
        x.last = 1'b0;
        step_results.push_back(x);
    endfunction

    function automatic void clear_tables();
        for (int s = 0; s < NSLOT; s++)
        begin
            slot_used[s] = 0;
            slot_blocked[s] = 0;
            for (int r = 0; r < NCLS; r++)
            begin
                held_units[s][r] = 0;
                waiting_on[s][r] = 0;
            end
        end
        for (int r = 0; r < NCLS; r++)
        begin
            free_units[r] = units_per_class;
            waitq_head[r] = 0;
            waitq_tail[r] = 0;
            waitq_cnt[r] = 0;
        end
        rr_next = 0;
    endfunction

    // Hand free units of one class to queued waiters in FIFO order
    function automatic void serve_waiters(int r, int maxn);
        int w;
        while (maxn > 0 && waitq_cnt[r] > 0 && free_units[r] > 0)
        begin
            w = int'(waitq[r][waitq_head[r]]);
            waitq_head[r] = (waitq_head[r] + 1) % NSLOT;
            waitq_cnt[r]--;
            free_units[r]--;
            held_units[w][r]++;
            slot_blocked[w] = 0;
            waiting_on[w][r] = 0;
            emit(KD_GRANT, w, r);
            maxn--;
        end
    endfunction

    // Drop the slot from every wait queue, then return its units
    function automatic void release_slot(int s);
        logic [3:0] tmp [NSLOT];
        int n;
        int sum;
        for (int r = 0; r < NCLS; r++)
        begin
            if (waitq_cnt[r] == 0)
                continue;
            n = 0;
            for (int k = 0; k < waitq_cnt[r]; k++)
                if (waitq[r][(waitq_head[r] + k) % NSLOT] != s[3:0])
                begin
                    tmp[n] = waitq[r][(waitq_head[r] + k) % NSLOT];
                    n++;
                end
            for (int k = 0; k < n; k++)
                waitq[r][k] = tmp[k];
            waitq_head[r] = 0;
            waitq_tail[r] = n % NSLOT;
            waitq_cnt[r] = n;
        end
        slot_blocked[s] = 0;
        for (int r = 0; r < NCLS; r++)
            waiting_on[s][r] = 0;
        for (int r = 0; r < NCLS; r++)
        begin
            if (held_units[s][r] == 0)
                continue;
            sum = int'(free_units[r]) + int'(held_units[s][r]);
            free_units[r] = (sum > 255) ? 8'hFF : sum[7:0];
            held_units[s][r] = 0;
            serve_waiters(r, NSLOT);
        end
    endfunction

    // Multi-instance safety test; returns the lowest stuck slot or NSLOT
    function automatic int lowest_deadlocked();
        int  avail [NCLS];
        bit  finished [NSLOT];
        bit  progress;
        bit  ok;
        for (int r = 0; r < NCLS; r++)
            avail[r] = int'(free_units[r]);
        for (int i = 0; i < NSLOT; i++)
            finished[i] = !slot_used[i];
        progress = 1;
        while (progress)
        begin
            progress = 0;
            for (int i = 0; i < NSLOT; i++)
            begin
                if (finished[i])
                    continue;
                ok = 1;
                for (int r = 0; r < NCLS; r++)
                    if (waiting_on[i][r] && avail[r] == 0)
                        ok = 0;
                if (ok)
                begin
                    for (int r = 0; r < NCLS; r++)
                        avail[r] += int'(held_units[i][r]);
                    finished[i] = 1;
                    progress = 1;
                end
            end
        end
        for (int i = 0; i < NSLOT; i++)
            if (!finished[i])
                return i;
        return NSLOT;
    endfunction

    // Work out the results of one accepted request and advance the tables
    function automatic void predict_allocator(cmd_t c);
        int s;
        int r;
        int v;
        bit found;
        s = int'(c.slot);
        r = int'(c.resource);
        step_results.delete();
        case (c.func)
            FN_REQUEST:
                if (!slot_used[s] || slot_blocked[s])
                    emit(KD_REJECT, 0, 0);
                else if (free_units[r] > 0)
                begin
                    free_units[r]--;
                    held_units[s][r]++;
                    emit(KD_GRANT, s, r);
                end
                else
                begin
                    slot_blocked[s] = 1;
                    waiting_on[s][r] = 1;
                    if (waitq_cnt[r] < NSLOT)
                    begin
                        waitq[r][waitq_tail[r]] = s[3:0];
                        waitq_tail[r] = (waitq_tail[r] + 1) % NSLOT;
                        waitq_cnt[r]++;
                    end
                    emit(KD_BLOCKED, s, r);
                    n_blocks++;
                end
            FN_RELEASE:
                if (held_units[s][r] == 0)
                    emit(KD_REJECT, 0, 0);
                else
                begin
                    held_units[s][r]--;
                    if (free_units[r] < 255)
                        free_units[r]++;
                    serve_waiters(r, 1);
                    emit(KD_TURN, s, 0);
                end
            FN_TERMINATE:
                if (!slot_used[s])
                    emit(KD_REJECT, 0, 0);
                else
                begin
                    release_slot(s);
                    slot_used[s] = 0;
                    emit(KD_ACK, s, 0);
                end
            FN_DETECT:
            begin
                v = lowest_deadlocked();
                while (v < NSLOT)
                begin
                    emit(KD_KILL, v, 0);
                    n_kills++;
                    release_slot(v);
                    slot_used[v] = 0;
                    v = lowest_deadlocked();
                end
                emit(KD_CLEAR, 0, 0);
            end
            FN_ADMIT:
            begin
                v = NSLOT;
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!slot_used[i])
                        v = i;
                if (v == NSLOT)
                    emit(KD_REJECT, 0, 0);
                else
                begin
                    slot_used[v] = 1;
                    slot_blocked[v] = 0;
                    for (int k = 0; k < NCLS; k++)
                    begin
                        held_units[v][k] = 0;
                        waiting_on[v][k] = 0;
                    end
                    emit(KD_ACK, v, 0);
                end
            end
            FN_DISPATCH:
            begin
                found = 0;
                for (int k = 0; k < NSLOT && !found; k++)
                begin
                    v = rr_next;
                    rr_next = (v + 1) % NSLOT;
                    if (slot_used[v] && !slot_blocked[v])
                    begin
                        emit(KD_TURN, v, 0);
                        found = 1;
                    end
                end
                if (!found)
                    emit(KD_REJECT, 0, 0);
            end
            FN_INIT:
            begin
                clear_tables();
                emit(KD_ACK, 0, 0);
            end
            default:
                emit(KD_REJECT, 0, 0);
        endcase
        step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            pending_results.push_back(step_results[i]);
    endfunction

    function automatic bit same_result(res_t a, res_t b);
        return a.kind == b.kind && a.target_slot == b.target_slot
            && a.resource_res == b.resource_res && a.last == b.last;
    endfunction

    // Check each drained result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d slot=%0d class=%0d last=%0d",
                         $time, res.kind, res.target_slot, res.resource_res, res.last);
                n_errors++;
            end
            else
            begin
                if (!same_result(pending_results[0], res))
                begin
                    $display("%0t: mismatch expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             $time, pending_results[0].kind, pending_results[0].target_slot,
                             pending_results[0].resource_res, pending_results[0].last,
                             res.kind, res.target_slot, res.resource_res, res.last);
                    n_errors++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // Result-side stall pattern, with one long hold-off on demand
    initial
    begin
        int mode;
        int span;
        res_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            if (long_hold)
            begin
                res_stall = 1'b1;
                repeat (400) @(negedge clk);
                long_hold = 0;
                res_stall = 1'b0;
            end
            for (int k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    0: res_stall = 1'b0;
                    1: res_stall = ($urandom_range(0, 3) == 0);
                    2: res_stall = ($urandom_range(0, 1) == 0);
                    default: res_stall = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offer one request and hold it until taken
    task automatic send_request(cmd_t c);
        @(negedge clk);
        cmd = c;
        cmd_valid = 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_allocator(c);
        n_requests++;
    endtask

    // Drain, let the sequencer settle, then load the register
    task automatic write_units(logic [7:0] val);
        @(negedge clk);
        cmd_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (40) @(negedge clk);
        cfg_data = val;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        units_per_class = val;
    endtask

    function automatic cmd_t mk_cmd(logic [2:0] f, int s, int r);
        cmd_t c;
        c.func = f;
        c.slot = s[3:0];
        c.resource = r[2:0];
        return c;
    endfunction

    function automatic void add_row(logic [2:0] f, int s, int r, bit chk,
                                    kind_t k, int ts, int tr);
        row_t w;
        w.wr = 0;
        w.val = 0;
        w.c = mk_cmd(f, s, r);
        w.chk = chk;
        w.e.kind = k;
        w.e.target_slot = ts[3:0];
        w.e.resource_res = tr[2:0];
        w.e.last = 1'b1;
        directed.push_back(w);
    endfunction

    function automatic void add_cfg(logic [7:0] val);
        row_t w;
        w.wr = 1;
        w.val = val;
        w.chk = 0;
        directed.push_back(w);
    endfunction

    // Random request biased toward legal traffic on the live tables
    function automatic cmd_t pick_request();
        int sel;
        int s;
        int r;
        int live[$];
        int owned[$];
        sel = $urandom_range(0, 99);
        s = $urandom_range(0, NSLOT - 1);
        r = $urandom_range(0, NCLS - 1);
        for (int i = 0; i < NSLOT; i++)
        begin
            if (slot_used[i] && !slot_blocked[i])
                live.push_back(i);
            for (int k = 0; k < NCLS; k++)
                if (held_units[i][k] != 0)
                    owned.push_back(i * NCLS + k);
        end
        if (sel < 40)
        begin
            if (live.size() > 0 && $urandom_range(0, 9) < 8)
                s = live[$urandom_range(0, live.size() - 1)];
            return mk_cmd(FN_REQUEST, s, r);
        end
        if (sel < 58)
        begin
            if (owned.size() > 0 && $urandom_range(0, 9) < 8)
            begin
                sel = owned[$urandom_range(0, owned.size() - 1)];
                s = sel / NCLS;
                r = sel % NCLS;
            end
            return mk_cmd(FN_RELEASE, s, r);
        end
        if (sel < 65) return mk_cmd(FN_TERMINATE, s, r);
        if (sel < 74) return mk_cmd(FN_DETECT, s, r);
        if (sel < 85) return mk_cmd(FN_ADMIT, s, r);
        if (sel < 94) return mk_cmd(FN_DISPATCH, s, r);
        if (sel < 97) return mk_cmd(FN_INIT, s, r);
        return mk_cmd(FN_UNDEF, s, r);
    endfunction

    // Stimulus
    initial
    begin
        logic [7:0] phase_units [5];
        int burst;
        int timeout;
        cmd_t c;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_data = IPC_RESET;
        long_hold = 0;
        n_errors = 0;
        n_requests = 0;
        n_results = 0;
        n_kills = 0;
        n_blocks = 0;
        units_per_class = IPC_RESET;
        clear_tables();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty tables after reset, then basic operations
        add_row(FN_DISPATCH, 0, 0, 1, KD_REJECT, 0, 0);
        add_row(FN_REQUEST, 0, 0, 1, KD_REJECT, 0, 0);
        add_row(FN_RELEASE, 15, 7, 1, KD_REJECT, 0, 0);
        add_row(FN_TERMINATE, 15, 0, 1, KD_REJECT, 0, 0);
        add_row(FN_DETECT, 0, 0, 1, KD_CLEAR, 0, 0);
        add_row(FN_UNDEF, 15, 7, 1, KD_REJECT, 0, 0);
        add_row(FN_ADMIT, 0, 0, 1, KD_ACK, 0, 0);
        add_row(FN_ADMIT, 0, 0, 1, KD_ACK, 1, 0);
        add_row(FN_REQUEST, 0, 7, 1, KD_GRANT, 0, 7);
        add_row(FN_DISPATCH, 0, 0, 1, KD_TURN, 0, 0);
        add_row(FN_RELEASE, 0, 7, 1, KD_TURN, 0, 0);
        add_row(FN_TERMINATE, 1, 0, 1, KD_ACK, 1, 0);
        // One unit per class: build a two-slot cycle and let detect break it
        add_cfg(8'd1);
        add_row(FN_INIT, 0, 0, 1, KD_ACK, 0, 0);
        add_row(FN_ADMIT, 0, 0, 1, KD_ACK, 0, 0);
        add_row(FN_ADMIT, 0, 0, 1, KD_ACK, 1, 0);
        add_row(FN_ADMIT, 0, 0, 1, KD_ACK, 2, 0);
        add_row(FN_REQUEST, 0, 0, 1, KD_GRANT, 0, 0);
        add_row(FN_REQUEST, 1, 1, 1, KD_GRANT, 1, 1);
        add_row(FN_REQUEST, 0, 1, 1, KD_BLOCKED, 0, 1);
        add_row(FN_REQUEST, 2, 1, 1, KD_BLOCKED, 2, 1);
        add_row(FN_REQUEST, 1, 0, 1, KD_BLOCKED, 1, 0);
        add_row(FN_REQUEST, 0, 2, 1, KD_REJECT, 0, 0);
        add_row(FN_DISPATCH, 0, 0, 1, KD_REJECT, 0, 0);
        add_row(FN_DETECT, 0, 0, 0, KD_CLEAR, 0, 0);
        // A terminating slot must not be handed its own freed unit
        add_row(FN_TERMINATE, 1, 0, 0, KD_ACK, 1, 0);

        foreach (directed[i])
        begin
            if (directed[i].wr)
                write_units(directed[i].val);
            else
            begin
                send_request(directed[i].c);
                if (directed[i].chk
                    && (step_results.size() != 1
                        || !same_result(step_results[0], directed[i].e)))
                begin
                    $display("%0t: row %0d expected %0d/%0d/%0d got %0d results, first %0d/%0d",
                             $time, i, directed[i].e.kind, directed[i].e.target_slot,
                             directed[i].e.resource_res, step_results.size(),
                             step_results[0].kind, step_results[0].target_slot);
                    n_errors++;
                end
            end
        end

        // Random phases over several unit counts, the extremes among them
        phase_units[0] = 8'd255;
        phase_units[1] = 8'd2;
        phase_units[2] = 8'd1;
        phase_units[3] = 8'($urandom_range(3, 254));
        phase_units[4] = IPC_RESET;
        for (int p = 0; p < 5; p++)
        begin
            write_units(phase_units[p]);
            send_request(mk_cmd(FN_INIT, $urandom_range(0, 15), $urandom_range(0, 7)));
            burst = $urandom_range(1, 12);
            for (int n = 0; n < 80; n++)
            begin
                if (p == 1 && n == 30)
                    long_hold = 1;
                if (p == 3 && n == 40)
                begin
                    @(negedge clk);
                    cmd_valid = 1'b0;
                    wait (pending_results.size() == 0);
                end
                c = pick_request();
                send_request(c);
                burst--;
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 12);
                    if (p != 2)
                    begin
                        @(negedge clk);
                        cmd_valid = 1'b0;
                        repeat ($urandom_range(0, 5)) @(negedge clk);
                    end
                end
            end
        end

        // Drain and let the sequencer settle
        @(negedge clk);
        cmd_valid = 1'b0;
        timeout = 0;
        while (pending_results.size() != 0 && timeout < 200000)
        begin
            @(posedge clk);
            timeout++;
        end
        repeat (100) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
            n_errors++;
        end
        $display("Covered %0d requests and %0d results over five unit counts,",
                 n_requests, n_results);
        $display("with %0d blocked requests and %0d deadlock victims.", n_blocks, n_kills);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
